/* rtl/core/tmt_pkg.sv */
// ----------------------------------------------------------------------------
// tmt_pkg
// Shared types and constants of the TinyMT32 generator: configuration set,
// micro-operations, jump conditions, control word and datapath status.
// ----------------------------------------------------------------------------
package tmt_pkg;

   localparam int WordWidth   = 32;
   localparam int StateWords  = 4;
   localparam int StateBits   = WordWidth * StateWords;
   localparam int ColIdxWidth = $clog2(StateBits);
   localparam int PcWidth     = 5;
   localparam int ProgDepth   = 2 ** PcWidth;
   localparam int DirectBits  = 16;
   localparam int BootSteps   = 8;

   localparam logic [WordWidth-1:0] StepMask     = 32'h7fff_ffff;
   localparam logic [WordWidth-1:0] InitMult     = 32'd1812433253;
   localparam logic [WordWidth-1:0] SeedReset    = 32'h0000_0000;
   localparam logic [WordWidth-1:0] MatOneReset  = 32'h8f70_11ee;
   localparam logic [WordWidth-1:0] MatTwoReset  = 32'hfc78_ff1f;
   localparam logic [WordWidth-1:0] TemperReset  = 32'h3793_fdff;
   localparam logic [2:0]           InitLastRound = 3'd7;

   typedef enum logic [1:0] {
      CSR_SEED       = 2'd0,
      CSR_MATRIX_ONE = 2'd1,
      CSR_MATRIX_TWO = 2'd2,
      CSR_TEMPER     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [WordWidth-1:0] seed;
      logic [WordWidth-1:0] matrix_one;
      logic [WordWidth-1:0] matrix_two;
      logic [WordWidth-1:0] temper_matrix;
   } cfg_type;

   typedef enum logic [4:0] {
      OP_NOP,
      OP_LOAD_SEED,
      OP_INIT_MUL,
      OP_INIT_XOR,
      OP_LOAD_EIGHT,
      OP_STEP_DEC,
      OP_LOAD_SKIP,
      OP_STEP,
      OP_TEMPER,
      OP_SCALE,
      OP_OUTPUT,
      OP_BUILD,
      OP_LOAD_VEC_S,
      OP_ACC,
      OP_APPLY,
      OP_SHIFT,
      OP_READ_COL,
      OP_LOAD_VEC_MEM,
      OP_WRITE_COL,
      OP_SWAP
   } op_type;

   typedef enum logic [3:0] {
      C_NEXT,
      C_ALWAYS,
      C_NO_ITEM,
      C_NO_RESEED,
      C_SKIP_BIG,
      C_CNT_ZERO,
      C_CNT_MORE,
      C_CNT_LAST,
      C_BIT_CLEAR,
      C_INIT_MORE,
      C_COL_MORE,
      C_ROW_MORE,
      C_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type              op;
      cond_type            cond;
      logic [PcWidth-1:0]  target;
   } ctrl_word_type;

   typedef struct packed {
      logic item;
      logic reseed;
      logic skip_big;
      logic cnt_zero;
      logic cnt_more;
      logic cnt_last;
      logic bit_clear;
      logic init_more;
      logic col_more;
      logic row_more;
      logic out_busy;
   } status_type;

endpackage

/* rtl/core/tmt_sequencer.sv */
// ----------------------------------------------------------------------------
// tmt_sequencer
// Microprogram ROM, step counter and jump logic. One control word per step
// selects the datapath operation and an optional conditional jump.
// ----------------------------------------------------------------------------
module tmt_sequencer
   import tmt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  status_type status_i,
   output op_type     op_o,
   output logic       idle_o
);

   localparam logic [PcWidth-1:0] PcBoot     = PcWidth'(0);
   localparam logic [PcWidth-1:0] PcInitMul  = PcWidth'(1);
   localparam logic [PcWidth-1:0] PcBootStep = PcWidth'(4);
   localparam logic [PcWidth-1:0] PcSkip     = PcWidth'(6);
   localparam logic [PcWidth-1:0] PcDirect   = PcWidth'(8);
   localparam logic [PcWidth-1:0] PcDraw     = PcWidth'(9);
   localparam logic [PcWidth-1:0] PcOutput   = PcWidth'(12);
   localparam logic [PcWidth-1:0] PcIdle     = PcWidth'(13);
   localparam logic [PcWidth-1:0] PcBuild    = PcWidth'(16);
   localparam logic [PcWidth-1:0] PcBitLoop  = PcWidth'(17);
   localparam logic [PcWidth-1:0] PcApplyAcc = PcWidth'(19);
   localparam logic [PcWidth-1:0] PcShift    = PcWidth'(21);
   localparam logic [PcWidth-1:0] PcReadCol  = PcWidth'(22);
   localparam logic [PcWidth-1:0] PcSqAcc    = PcWidth'(24);

   function automatic ctrl_word_type cw(input op_type op, input cond_type cond,
                                        input logic [PcWidth-1:0] target);
      ctrl_word_type w;
      w.op     = op;
      w.cond   = cond;
      w.target = target;
      return w;
   endfunction

   // reseed, draw, idle, then the matrix jump for long skips
   localparam ctrl_word_type Program [ProgDepth] = '{
      0:  cw(OP_LOAD_SEED,    C_NEXT,      PcBoot),
      1:  cw(OP_INIT_MUL,     C_NEXT,      PcBoot),
      2:  cw(OP_INIT_XOR,     C_INIT_MORE, PcInitMul),
      3:  cw(OP_LOAD_EIGHT,   C_NEXT,      PcBoot),
      4:  cw(OP_STEP_DEC,     C_CNT_MORE,  PcBootStep),
      5:  cw(OP_NOP,          C_NO_ITEM,   PcIdle),
      6:  cw(OP_LOAD_SKIP,    C_SKIP_BIG,  PcBuild),
      7:  cw(OP_NOP,          C_CNT_ZERO,  PcDraw),
      8:  cw(OP_STEP_DEC,     C_CNT_MORE,  PcDirect),
      9:  cw(OP_STEP,         C_NEXT,      PcBoot),
      10: cw(OP_TEMPER,       C_NEXT,      PcBoot),
      11: cw(OP_SCALE,        C_NEXT,      PcBoot),
      12: cw(OP_OUTPUT,       C_OUT_BUSY,  PcOutput),
      13: cw(OP_NOP,          C_NO_ITEM,   PcIdle),
      14: cw(OP_NOP,          C_NO_RESEED, PcSkip),
      15: cw(OP_NOP,          C_ALWAYS,    PcBoot),
      16: cw(OP_BUILD,        C_COL_MORE,  PcBuild),
      17: cw(OP_NOP,          C_BIT_CLEAR, PcShift),
      18: cw(OP_LOAD_VEC_S,   C_NEXT,      PcBoot),
      19: cw(OP_ACC,          C_ROW_MORE,  PcApplyAcc),
      20: cw(OP_APPLY,        C_NEXT,      PcBoot),
      21: cw(OP_SHIFT,        C_CNT_LAST,  PcDraw),
      22: cw(OP_READ_COL,     C_NEXT,      PcBoot),
      23: cw(OP_LOAD_VEC_MEM, C_NEXT,      PcBoot),
      24: cw(OP_ACC,          C_ROW_MORE,  PcSqAcc),
      25: cw(OP_WRITE_COL,    C_COL_MORE,  PcReadCol),
      26: cw(OP_SWAP,         C_ALWAYS,    PcBitLoop),
      default: cw(OP_NOP,     C_ALWAYS,    PcIdle)
   };

   logic [PcWidth-1:0] pc_ff;
   logic [PcWidth-1:0] pc_in;
   ctrl_word_type      word;
   logic               take;

   assign word = Program[pc_ff];

   always_comb begin
      unique case (word.cond)
         C_NEXT:      take = 1'b0;
         C_ALWAYS:    take = 1'b1;
         C_NO_ITEM:   take = !status_i.item;
         C_NO_RESEED: take = !status_i.reseed;
         C_SKIP_BIG:  take = status_i.skip_big;
         C_CNT_ZERO:  take = status_i.cnt_zero;
         C_CNT_MORE:  take = status_i.cnt_more;
         C_CNT_LAST:  take = status_i.cnt_last;
         C_BIT_CLEAR: take = status_i.bit_clear;
         C_INIT_MORE: take = status_i.init_more;
         C_COL_MORE:  take = status_i.col_more;
         C_ROW_MORE:  take = status_i.row_more;
         C_OUT_BUSY:  take = status_i.out_busy;
         default:     take = 1'b1;
      endcase
      pc_in = take ? word.target : pc_ff + PcWidth'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PcBoot;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign op_o   = word.op;
   assign idle_o = (pc_ff == PcIdle);

`ifndef SYNTH
   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == PcIdle && !status_i.item) |=> (pc_ff == PcIdle))
      else $error("sequencer left idle without an item");
`endif

endmodule

/* rtl/core/tmt_datapath.sv */
// ----------------------------------------------------------------------------
// tmt_datapath
// State words, step and tempering logic, shared 32x32 multiplier, skip
// counter and the GF(2) jump matrix memory, driven by the micro-operations.
// ----------------------------------------------------------------------------
module tmt_datapath
   import tmt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg_i,
   input  op_type               op_i,
   input  logic                 idle_i,
   output status_type           status_o,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_reseed,
   input  logic [WordWidth-1:0] req_skip_steps,
   input  logic [WordWidth-1:0] req_scale_range,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [WordWidth-1:0] rsp_random_value
);

   localparam int MemDepth = 2 * StateBits;
   localparam int MemAddrWidth = ColIdxWidth + 1;

   function automatic logic [StateBits-1:0] step_fn(input logic [StateBits-1:0] s,
                                                    input logic [WordWidth-1:0] m1,
                                                    input logic [WordWidth-1:0] m2);
      logic [WordWidth-1:0] x;
      logic [WordWidth-1:0] y;
      logic [WordWidth-1:0] n1;
      logic [WordWidth-1:0] n2;
      y  = s[127:96];
      x  = (s[31:0] & StepMask) ^ s[63:32] ^ s[95:64];
      x  = x ^ (x << 1);
      y  = y ^ (y >> 1) ^ x;
      n1 = s[95:64];
      n2 = x ^ (y << 10);
      if (y[0]) begin
         n1 = n1 ^ m1;
         n2 = n2 ^ m2;
      end
      return {y, n2, n1, s[63:32]};
   endfunction

   logic                          boot_ff, boot_in;
   logic                          item_ff, item_in;
   logic                          reseed_ff, reseed_in;
   logic [WordWidth-1:0]          skip_ff, skip_in;
   logic [WordWidth-1:0]          range_ff, range_in;
   logic [StateWords-1:0][WordWidth-1:0] state_ff, state_in;
   logic [WordWidth-1:0]          cnt_ff, cnt_in;
   logic [ColIdxWidth-1:0]        idx_ff, idx_in;
   logic [ColIdxWidth-1:0]        jdx_ff, jdx_in;
   logic                          bank_ff, bank_in;
   logic [StateBits-1:0]          vec_ff, vec_in;
   logic [StateBits-1:0]          acc_ff, acc_in;
   logic                          pend_ff, pend_in;
   logic [ColIdxWidth-1:0]        pend_j_ff, pend_j_in;
   logic [2*WordWidth-1:0]        mul_ff, mul_in;
   logic [WordWidth-1:0]          word_ff, word_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [WordWidth-1:0]          rsp_value_ff, rsp_value_in;
   logic [StateBits-1:0]          rdata_ff;
   logic [StateBits-1:0]          jmat_mem [MemDepth];

   logic                          req_accept;
   logic                          out_busy;
   logic [WordWidth-1:0]          m1_eff, m2_eff;
   logic [WordWidth-1:0]          mul_a, mul_b, init_p;
   logic [WordWidth-1:0]          t1;
   logic [StateBits-1:0]          acc_next;
   logic [StateBits-1:0]          unit_vec;
   logic                          rd_en, wr_en;
   logic [MemAddrWidth-1:0]       rd_addr, wr_addr;
   logic [StateBits-1:0]          wr_data;

   assign req_stall  = !idle_i || item_ff || boot_ff;
   assign req_accept = req_valid && !req_stall;
   assign out_busy   = rsp_valid_ff && rsp_stall;

   // the boot reseed runs on reset values, whatever gets written meanwhile
   assign m1_eff = boot_ff ? MatOneReset : cfg_i.matrix_one;
   assign m2_eff = boot_ff ? MatTwoReset : cfg_i.matrix_two;

   assign init_p   = state_ff[idx_ff[1:0] - 2'd1];
   assign t1       = state_ff[0] + (state_ff[2] >> 8);
   assign acc_next = acc_ff ^ ((pend_ff && vec_ff[pend_j_ff]) ? rdata_ff : '0);
   assign unit_vec = StateBits'(1) << idx_ff;

   always_comb begin
      mul_a = word_ff;
      mul_b = range_ff;
      if (op_i == OP_INIT_MUL) begin
         mul_a = init_p ^ (init_p >> 30);
         mul_b = InitMult;
      end
   end

   always_comb begin
      rd_en   = (op_i == OP_ACC) || (op_i == OP_READ_COL);
      rd_addr = {bank_ff, (op_i == OP_ACC) ? jdx_ff : idx_ff};
      wr_en   = (op_i == OP_BUILD) || (op_i == OP_WRITE_COL);
      wr_addr = {(op_i == OP_WRITE_COL) ? !bank_ff : bank_ff, idx_ff};
      wr_data = (op_i == OP_BUILD) ? step_fn(unit_vec, m1_eff, m2_eff) : acc_next;
   end

   always_comb begin
      boot_in      = boot_ff && !idle_i;
      item_in      = item_ff;
      reseed_in    = reseed_ff;
      skip_in      = skip_ff;
      range_in     = range_ff;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      jdx_in       = jdx_ff;
      bank_in      = bank_ff;
      vec_in       = vec_ff;
      acc_in       = acc_next;
      pend_in      = 1'b0;
      pend_j_in    = jdx_ff;
      mul_in       = mul_ff;
      word_in      = word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;

      if (req_accept) begin
         item_in   = 1'b1;
         reseed_in = req_reseed;
         skip_in   = req_skip_steps;
         range_in  = req_scale_range;
      end

      unique case (op_i)
         OP_NOP: begin
         end
         OP_LOAD_SEED: begin
            state_in[0] = boot_ff ? SeedReset : cfg_i.seed;
            state_in[1] = m1_eff;
            state_in[2] = m2_eff;
            state_in[3] = boot_ff ? TemperReset : cfg_i.temper_matrix;
            idx_in      = ColIdxWidth'(1);
         end
         OP_INIT_MUL: begin
            mul_in = (2*WordWidth)'(mul_a) * (2*WordWidth)'(mul_b);
         end
         OP_INIT_XOR: begin
            state_in[idx_ff[1:0]] = state_ff[idx_ff[1:0]]
                                    ^ (WordWidth'(idx_ff) + mul_ff[WordWidth-1:0]);
            idx_in = idx_ff + ColIdxWidth'(1);
         end
         OP_LOAD_EIGHT: begin
            cnt_in = WordWidth'(BootSteps);
         end
         OP_STEP_DEC: begin
            state_in = step_fn(state_ff, m1_eff, m2_eff);
            cnt_in   = cnt_ff - WordWidth'(1);
         end
         OP_LOAD_SKIP: begin
            cnt_in = skip_ff;
            idx_in = '0;
         end
         OP_STEP: begin
            state_in = step_fn(state_ff, m1_eff, m2_eff);
         end
         OP_TEMPER: begin
            word_in = state_ff[3] ^ t1 ^ (t1[0] ? cfg_i.temper_matrix : '0);
         end
         OP_SCALE: begin
            mul_in = (2*WordWidth)'(mul_a) * (2*WordWidth)'(mul_b);
         end
         OP_OUTPUT: begin
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = (range_ff != '0) ? mul_ff[2*WordWidth-1:WordWidth] : word_ff;
               item_in      = 1'b0;
            end
         end
         OP_BUILD: begin
            idx_in = idx_ff + ColIdxWidth'(1);
         end
         OP_LOAD_VEC_S: begin
            vec_in = state_ff;
            jdx_in = '0;
            acc_in = '0;
         end
         OP_ACC: begin
            pend_in = 1'b1;
            jdx_in  = jdx_ff + ColIdxWidth'(1);
         end
         OP_APPLY: begin
            state_in = acc_next;
         end
         OP_SHIFT: begin
            cnt_in = cnt_ff >> 1;
            idx_in = '0;
         end
         OP_READ_COL: begin
         end
         OP_LOAD_VEC_MEM: begin
            vec_in = rdata_ff;
            jdx_in = '0;
            acc_in = '0;
         end
         OP_WRITE_COL: begin
            idx_in = idx_ff + ColIdxWidth'(1);
         end
         OP_SWAP: begin
            bank_in = !bank_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         boot_ff      <= 1'b1;
         item_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bank_ff      <= 1'b0;
      end else begin
         boot_ff      <= boot_in;
         item_ff      <= item_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         bank_ff      <= bank_in;
      end
      reseed_ff    <= reseed_in;
      skip_ff      <= skip_in;
      range_ff     <= range_in;
      state_ff     <= state_in;
      cnt_ff       <= cnt_in;
      idx_ff       <= idx_in;
      jdx_ff       <= jdx_in;
      vec_ff       <= vec_in;
      acc_ff       <= acc_in;
      pend_j_ff    <= pend_j_in;
      mul_ff       <= mul_in;
      word_ff      <= word_in;
      rsp_value_ff <= rsp_value_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         jmat_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= jmat_mem[rd_addr];
      end
   end

   always_comb begin
      status_o.item      = item_ff;
      status_o.reseed    = reseed_ff;
      status_o.skip_big  = (skip_ff[WordWidth-1:DirectBits] != '0);
      status_o.cnt_zero  = (cnt_ff == '0);
      status_o.cnt_more  = (cnt_ff != WordWidth'(1));
      status_o.cnt_last  = (cnt_ff[WordWidth-1:1] == '0);
      status_o.bit_clear = !cnt_ff[0];
      status_o.init_more = (idx_ff[2:0] != InitLastRound);
      status_o.col_more  = (idx_ff != '1);
      status_o.row_more  = (jdx_ff != '1);
      status_o.out_busy  = out_busy;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_value = rsp_value_ff;

`ifndef SYNTH
   a_accept_after_boot: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> (!boot_ff && !item_ff))
      else $error("item taken during boot reseed or while busy");
   a_output_has_item: assert property (@(posedge clock) disable iff (reset)
      (op_i == OP_OUTPUT && !out_busy) |-> item_ff)
      else $error("result issued with no item in flight");
   a_pend_from_acc: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(op_i == OP_ACC))
      else $error("matrix read pending without an accumulate step");
`endif

endmodule

/* rtl/core/tinymt32_generator.sv */
// ----------------------------------------------------------------------------
// tinymt32_generator
// A reseed runs 7 init rounds and 8 state steps before the draw.
// Skips below 65536 apply one state step at a time; larger skips build the
//   step matrix, then per count bit apply it if the bit is set and square it
//   through the two-bank matrix memory unless it is the last bit.
// One item at a time; after reset a boot reseed runs, no item taken.
// ----------------------------------------------------------------------------
module tinymt32_generator
   import tmt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [1:0]           csr_index,
   input  logic [WordWidth-1:0] csr_wdata,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_reseed,
   input  logic [WordWidth-1:0] req_skip_steps,
   input  logic [WordWidth-1:0] req_scale_range,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [WordWidth-1:0] rsp_random_value
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   op_type     op;
   logic       idle;
   status_type status;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_SEED:       cfg_in.seed          = csr_wdata;
            CSR_MATRIX_ONE: cfg_in.matrix_one    = csr_wdata;
            CSR_MATRIX_TWO: cfg_in.matrix_two    = csr_wdata;
            CSR_TEMPER:     cfg_in.temper_matrix = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.seed          <= SeedReset;
         cfg_ff.matrix_one    <= MatOneReset;
         cfg_ff.matrix_two    <= MatTwoReset;
         cfg_ff.temper_matrix <= TemperReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tmt_sequencer u_sequencer (
      .clock    (clock),
      .reset    (reset),
      .status_i (status),
      .op_o     (op),
      .idle_o   (idle)
   );

   tmt_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cfg_i            (cfg_ff),
      .op_i             (op),
      .idle_i           (idle),
      .status_o         (status),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_reseed       (req_reseed),
      .req_skip_steps   (req_skip_steps),
      .req_scale_range  (req_scale_range),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_random_value (rsp_random_value)
   );

endmodule
